@@ design/mocp_pkg.sv @@
// Package for the market order CSV line parser.
// Holds the result record type, the status codes, character codes and
// saturation limits; no dependencies.
`default_nettype none

package mocp_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_RECORD    = 2'd0,
    ST_NO_HEADER = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  // Per-field parse phase, one-hot
  typedef enum logic [2:0] {
    PH_START  = 3'b001,
    PH_DIGITS = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  // Field positions within a line
  localparam logic [2:0] FLD_TIME   = 3'd0;
  localparam logic [2:0] FLD_ACTION = 3'd1;
  localparam logic [2:0] FLD_SIDE   = 3'd2;
  localparam logic [2:0] FLD_PRICE  = 3'd3;
  localparam logic [2:0] FLD_QTY    = 3'd4;
  localparam logic [2:0] FLD_ORDER  = 3'd5;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B     = 8'h42;

  // Header line count after reset
  localparam logic [1:0] HDR_LINES_RST = 2'd2;

  // Saturation limits, with limit/10 and limit%10 for the overflow test
  localparam logic [63:0] LIM_PRICE_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_PRICE_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM_QTY       = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] LIM_U64       = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [63:0] Q_PRICE_POS = LIM_PRICE_POS / 64'd10;
  localparam logic [63:0] Q_PRICE_NEG = LIM_PRICE_NEG / 64'd10;
  localparam logic [63:0] Q_QTY       = LIM_QTY / 64'd10;
  localparam logic [63:0] Q_U64       = LIM_U64 / 64'd10;

  localparam logic [3:0] R_PRICE_POS = 4'(LIM_PRICE_POS % 64'd10);
  localparam logic [3:0] R_PRICE_NEG = 4'(LIM_PRICE_NEG % 64'd10);
  localparam logic [3:0] R_QTY       = 4'(LIM_QTY % 64'd10);
  localparam logic [3:0] R_U64       = 4'(LIM_U64 % 64'd10);

  // Output queue sizing
  localparam int OUT_DEPTH = 3;
  localparam int OUT_IDX_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // One result beat
  typedef struct packed {
    logic [63:0]        event_time;
    logic [7:0]         action_code;
    logic               is_bid;
    logic signed [31:0] price_value;
    logic [31:0]        quantity;
    logic [63:0]        order_ident;
    status_t            status;
    logic               overflowed;
  } rec_t;

endpackage

`default_nettype wire

@@ design/mocp_field_core.sv @@
// Input stage register plus the per-byte field parser and line state.
// Depends on mocp_pkg; feeds a result beat per finished non-empty line.
`default_nettype none

module mocp_field_core
  import mocp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] header_lines,
  input  wire logic       in_take,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eoi,
  output logic            stage_vld,
  output logic            res_vld,
  output rec_t            res
);

  // Input stage
  logic       stage_vld_r;
  logic [7:0] stage_byte_r;
  logic       stage_eoi_r;

  // Parse state
  logic [1:0]  header_seen_r, header_seen_nxt;
  logic [2:0]  field_r, field_nxt;
  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] time_hold_r, time_hold_nxt;
  logic [7:0]  action_hold_r, action_hold_nxt;
  logic        bid_hold_r, bid_hold_nxt;
  logic [31:0] price_hold_r, price_hold_nxt;
  logic [31:0] qty_hold_r, qty_hold_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic        ovf_r, ovf_nxt;

  // Decode helpers
  logic        hdr_pending;
  logic        is_nl, is_comma, is_ws, is_digit, is_sign;
  logic [3:0]  dig;
  logic [63:0] lim, lim_q;
  logic [3:0]  lim_r;
  logic        too_big;
  logic [63:0] acc_mul;
  logic [63:0] step_acc;
  logic        step_ovf;
  phase_t      step_phase;
  rec_t        line_rec;

  assign stage_vld = stage_vld_r;

  // Stage register: payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= in_take;
    end
    if (in_take) begin
      stage_byte_r <= in_byte;
      stage_eoi_r  <= in_eoi;
    end
  end

  // Character classes
  always_comb begin
    hdr_pending = header_seen_r < header_lines;
    is_nl       = stage_byte_r == CH_NL;
    is_comma    = stage_byte_r == CH_COMMA;
    is_ws       = (stage_byte_r == CH_SPACE) || (stage_byte_r == CH_TAB) ||
                  (stage_byte_r == CH_CR) || (stage_byte_r == CH_VT) ||
                  (stage_byte_r == CH_FF);
    is_digit    = (stage_byte_r >= CH_ZERO) && (stage_byte_r <= CH_NINE);
    is_sign     = (field_r == FLD_PRICE) &&
                  ((stage_byte_r == CH_MINUS) || (stage_byte_r == CH_PLUS));
    dig         = 4'(stage_byte_r - CH_ZERO);
  end

  // Limit for the current field
  always_comb begin
    if (field_r == FLD_PRICE && neg_r) begin
      lim = LIM_PRICE_NEG; lim_q = Q_PRICE_NEG; lim_r = R_PRICE_NEG;
    end else if (field_r == FLD_PRICE) begin
      lim = LIM_PRICE_POS; lim_q = Q_PRICE_POS; lim_r = R_PRICE_POS;
    end else if (field_r == FLD_QTY) begin
      lim = LIM_QTY; lim_q = Q_QTY; lim_r = R_QTY;
    end else begin
      lim = LIM_U64; lim_q = Q_U64; lim_r = R_U64;
    end
  end

  // One decimal digit step: acc*10+d > lim exactly when acc > (lim-d)/10
  always_comb begin
    too_big = (acc_r > lim_q) || ((acc_r == lim_q) && (dig > lim_r));
    acc_mul = (acc_r << 3) + (acc_r << 1) + {60'd0, dig};
    step_acc   = acc_r;
    step_ovf   = ovf_r;
    step_phase = PH_DIGITS;
    if (!is_digit) begin
      step_phase = PH_STOP;
    end else if (too_big) begin
      step_acc = lim;
      step_ovf = 1'b1;
    end else begin
      step_acc = acc_mul;
    end
  end

  // Record for a finished non-empty line
  always_comb begin
    line_rec = '0;
    if (field_r == FLD_ORDER) begin
      line_rec.event_time  = time_hold_r;
      line_rec.action_code = action_hold_r;
      line_rec.is_bid      = bid_hold_r;
      line_rec.price_value = price_hold_r;
      line_rec.quantity    = qty_hold_r;
      line_rec.order_ident = acc_r;
      line_rec.status      = ST_RECORD;
      line_rec.overflowed  = ovf_r;
    end else begin
      line_rec.status = ST_MALFORMED;
    end
  end

  // Next state and result
  always_comb begin
    header_seen_nxt = header_seen_r;
    field_nxt       = field_r;
    phase_nxt       = phase_r;
    acc_nxt         = acc_r;
    neg_nxt         = neg_r;
    time_hold_nxt   = time_hold_r;
    action_hold_nxt = action_hold_r;
    bid_hold_nxt    = bid_hold_r;
    price_hold_nxt  = price_hold_r;
    qty_hold_nxt    = qty_hold_r;
    nonempty_nxt    = nonempty_r;
    ovf_nxt         = ovf_r;
    res_vld         = 1'b0;
    res             = '0;

    if (stage_vld_r) begin
      priority if (stage_eoi_r) begin
        // end of input: report missing header or flush, then full clear
        if (hdr_pending) begin
          res_vld    = 1'b1;
          res.status = ST_NO_HEADER;
        end else if (nonempty_r) begin
          res_vld = 1'b1;
          res     = line_rec;
        end
        header_seen_nxt = 2'd0;
      end else if (hdr_pending) begin
        if (is_nl) begin
          header_seen_nxt = header_seen_r + 2'd1;
        end
      end else if (is_nl) begin
        if (nonempty_r) begin
          res_vld = 1'b1;
          res     = line_rec;
        end
      end else begin
        nonempty_nxt = 1'b1;
        if (is_comma && field_r < FLD_ORDER) begin
          // close the field
          if (field_r == FLD_TIME) begin
            time_hold_nxt = acc_r;
          end else if (field_r == FLD_PRICE) begin
            price_hold_nxt = neg_r ? 32'(32'd0 - acc_r[31:0]) : acc_r[31:0];
          end else if (field_r == FLD_QTY) begin
            qty_hold_nxt = acc_r[31:0];
          end
          field_nxt = field_r + 3'd1;
          phase_nxt = PH_START;
          acc_nxt   = 64'd0;
          neg_nxt   = 1'b0;
        end else if (field_r == FLD_ACTION || field_r == FLD_SIDE) begin
          // character fields take their first byte only
          if (phase_r == PH_START) begin
            if (field_r == FLD_ACTION) begin
              action_hold_nxt = stage_byte_r;
            end else begin
              bid_hold_nxt = stage_byte_r == CH_B;
            end
            phase_nxt = PH_STOP;
          end
        end else begin
          // decimal field
          unique case (phase_r)
            PH_START: begin
              if (!is_ws) begin
                if (is_sign) begin
                  phase_nxt = PH_DIGITS;
                  neg_nxt   = stage_byte_r == CH_MINUS;
                end else begin
                  phase_nxt = step_phase;
                  acc_nxt   = step_acc;
                  ovf_nxt   = step_ovf;
                end
              end
            end
            PH_DIGITS: begin
              phase_nxt = step_phase;
              acc_nxt   = step_acc;
              ovf_nxt   = step_ovf;
            end
            PH_STOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      // line end or input end clears the line
      if (stage_eoi_r || (!hdr_pending && is_nl)) begin
        field_nxt       = FLD_TIME;
        phase_nxt       = PH_START;
        acc_nxt         = 64'd0;
        neg_nxt         = 1'b0;
        time_hold_nxt   = 64'd0;
        action_hold_nxt = 8'd0;
        bid_hold_nxt    = 1'b0;
        price_hold_nxt  = 32'd0;
        qty_hold_nxt    = 32'd0;
        nonempty_nxt    = 1'b0;
        ovf_nxt         = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_seen_r <= 2'd0;
      field_r       <= FLD_TIME;
      phase_r       <= PH_START;
      acc_r         <= 64'd0;
      neg_r         <= 1'b0;
      time_hold_r   <= 64'd0;
      action_hold_r <= 8'd0;
      bid_hold_r    <= 1'b0;
      price_hold_r  <= 32'd0;
      qty_hold_r    <= 32'd0;
      nonempty_r    <= 1'b0;
      ovf_r         <= 1'b0;
    end else begin
      header_seen_r <= header_seen_nxt;
      field_r       <= field_nxt;
      phase_r       <= phase_nxt;
      acc_r         <= acc_nxt;
      neg_r         <= neg_nxt;
      time_hold_r   <= time_hold_nxt;
      action_hold_r <= action_hold_nxt;
      bid_hold_r    <= bid_hold_nxt;
      price_hold_r  <= price_hold_nxt;
      qty_hold_r    <= qty_hold_nxt;
      nonempty_r    <= nonempty_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

  // Checks
  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_r <= FLD_ORDER)
    else $error("field index past last field");

  a_res_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> stage_vld_r)
    else $error("result without a staged beat");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_vld_r && stage_eoi_r) |=>
      (header_seen_r == 2'd0 && field_r == FLD_TIME && !nonempty_r && !ovf_r))
    else $error("end of input left parse state behind");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.status != ST_RECORD) |->
      (res.event_time == 64'd0 && res.order_ident == 64'd0 && !res.overflowed))
    else $error("error result carries payload");

endmodule

`default_nettype wire

@@ design/mocp_out_fifo.sv @@
// Small result queue between the parser and the output channel.
// Depends on mocp_pkg for the record type and depth.
`default_nettype none

module mocp_out_fifo
  import mocp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire rec_t                 push_data,
  input  wire logic                 pop,
  output logic                      head_vld,
  output rec_t                      head_data,
  output logic [OUT_CNT_W-1:0]      count
);

  rec_t                 slot_r [OUT_DEPTH];
  logic [OUT_IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] count_r;

  function automatic logic [OUT_IDX_W-1:0] ptr_inc(input logic [OUT_IDX_W-1:0] p);
    logic [OUT_IDX_W-1:0] n;
    n = (p == OUT_IDX_W'(OUT_DEPTH - 1)) ? '0 : p + OUT_IDX_W'(1);
    return n;
  endfunction

  // Slot write
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + OUT_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - OUT_CNT_W'(1);
      end
    end
  end

  assign head_vld  = count_r != '0;
  assign head_data = slot_r[rd_ptr_r];
  assign count     = count_r;

  // Checks
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r < OUT_CNT_W'(OUT_DEPTH)))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

@@ design/market_order_csv_line_parser.sv @@
// Top level of the market order CSV line parser: header line register,
// parser core and result queue. Depends on mocp_pkg, mocp_field_core, mocp_out_fifo.
//
//  channel | direction | handshake           | beat
//  in_     | input     | in_valid/in_ready   | one text byte or end-of-input mark
//  out_    | output    | out_valid/out_ready | one order record or status report
//  cfg_    | input     | cfg_we              | header line count, 2 bits
//
// One byte per cycle sustained while the queue has room; a byte is registered in the input
// stage and its record (if any) is then pushed into the result queue, whose head drives out_.
// in_ready depends only on registers: the three-entry result queue plus the input
// stage must have room, so out_ready held low stalls the input.
// Synchronous active-low reset clears parse state, queue and sets header count to 2.
`default_nettype none

module market_order_csv_line_parser
  import mocp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_end_of_input,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             out_event_time,
  output logic [7:0]              out_action_code,
  output logic                    out_is_bid,
  output logic signed [31:0]      out_price_value,
  output logic [31:0]             out_quantity,
  output logic [63:0]             out_order_ident,
  output logic [1:0]              out_status,
  output logic                    out_overflowed,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata
);

  localparam int SUM_W = OUT_CNT_W + 1;

  logic [1:0]           header_lines_r;
  logic                 in_take;
  logic                 stage_vld;
  logic                 res_vld;
  rec_t                 res;
  rec_t                 head;
  logic [OUT_CNT_W-1:0] q_count;

  // Header line count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_lines_r <= HDR_LINES_RST;
    end else if (cfg_we) begin
      header_lines_r <= cfg_wdata;
    end
  end

  // Room for the new byte's result after everything already in flight
  assign in_ready = ({1'b0, q_count} + SUM_W'(stage_vld)) < SUM_W'(OUT_DEPTH);
  assign in_take  = in_valid && in_ready;

  mocp_field_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .header_lines (header_lines_r),
    .in_take      (in_take),
    .in_byte      (in_byte),
    .in_eoi       (in_end_of_input),
    .stage_vld    (stage_vld),
    .res_vld      (res_vld),
    .res          (res)
  );

  mocp_out_fifo u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop       (out_valid && out_ready),
    .head_vld  (out_valid),
    .head_data (head),
    .count     (q_count)
  );

  // Result fields
  assign out_event_time  = head.event_time;
  assign out_action_code = head.action_code;
  assign out_is_bid      = head.is_bid;
  assign out_price_value = head.price_value;
  assign out_quantity    = head.quantity;
  assign out_order_ident = head.order_ident;
  assign out_status      = head.status;
  assign out_overflowed  = head.overflowed;

endmodule

`default_nettype wire
